FILE: src/afbu_pkg.sv
// ----------------------------------------------------------------------------
// afbu_pkg
// Shared constants, types and the tanh lookup tables of the activation unit.
// ----------------------------------------------------------------------------
package afbu_pkg;

  localparam int FRAC_BITS     = 12;
  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int DATA_W        = 16;
  localparam int ROM_W         = 31;
  localparam int MAG_W         = FRAC_BITS + 4;
  localparam int ABS_W         = (DATA_W + 1 > MAG_W) ? DATA_W + 1 : MAG_W;
  localparam int SH_W          = FRAC_BITS + 4;
  localparam int POS_W         = MAG_W + IDX_W + 1;
  localparam int PROD_W        = ROM_W + SH_W;
  localparam int LOCAL_W       = FRAC_BITS + 1;
  localparam int LP_W          = 2 * FRAC_BITS + 1;
  localparam int MUL_W         = LOCAL_W + 1 + DATA_W;
  localparam int RND_W         = DATA_W + 2;

  localparam int APB_DATA_W    = 32;
  localparam int ADDR_W        = 4;
  localparam int REG_IDX_W     = ADDR_W - 2;

  localparam logic [ROM_W-1:0]   Q30_ONE = {1'b1, 30'd0};
  localparam logic [LOCAL_W-1:0] ONE_F   = {1'b1, {FRAC_BITS{1'b0}}};

  // Series argument 16/N in Q30.
  localparam logic [63:0] TAYLOR_STEP = (64'd1 << 34) / TABLE_ENTRIES;

  // Activation kinds; the unused code behaves as ReLU.
  localparam logic [1:0] KIND_RELU    = 2'd0;
  localparam logic [1:0] KIND_SIGMOID = 2'd1;
  localparam logic [1:0] KIND_TANH    = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_KIND    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DIR     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_GRAD_EN = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic       backward;
    logic       grad_en;
  } cfg_t;

  typedef logic [ROM_W-1:0] rom_t [TABLE_ENTRIES];

  // Restoring division, used only while the tables are built.
  function automatic logic [63:0] udiv64(input logic [63:0] num,
                                         input logic [63:0] dnm);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, dnm}) begin
        rem    = rem - {1'b0, dnm};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Builds tanh(8*i/TABLE_ENTRIES) in Q30. The decay ratio exp(-16/N) comes
  // from a truncated Taylor series, and e = exp(-2t) is stepped by that ratio.
  // With upper set, entry i holds the point above it, and 1.0 past the end.
  function automatic rom_t build_tanh_rom(input logic upper);
    rom_t        lo;
    rom_t        res;
    logic [63:0] one;
    logic [63:0] a;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] r;
    logic [63:0] den;
    logic [63:0] q;
    one  = 64'd1 << 30;
    a    = TAYLOR_STEP;
    sum  = one;
    term = one;
    e    = one;
    for (int k = 1; k <= 14; k++) begin
      term = udiv64((term * a) >> 30, 64'(k));
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    r = sum;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      den   = one + e;
      q     = udiv64(((one - e) << 30) + (den >> 1), den);
      lo[i] = q[ROM_W-1:0];
      e     = (e * r + (one >> 1)) >> 30;
    end
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (!upper) begin
        res[i] = lo[i];
      end else if (i + 1 < TABLE_ENTRIES) begin
        res[i] = lo[i + 1];
      end else begin
        res[i] = Q30_ONE;
      end
    end
    return res;
  endfunction

  localparam rom_t TANH_LO = build_tanh_rom(1'b0);
  localparam rom_t TANH_HI = build_tanh_rom(1'b1);

endpackage

FILE: src/afbu_regs.sv
// ----------------------------------------------------------------------------
// afbu_regs
// APB-style configuration registers: activation kind, direction, gradient
// enable.
// ----------------------------------------------------------------------------
module afbu_regs
  import afbu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kind     <= KIND_RELU;
      cfg.backward <= 1'b0;
      cfg.grad_en  <= 1'b1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_KIND:    cfg.kind     <= pwdata[1:0];
        REG_DIR:     cfg.backward <= pwdata[0];
        REG_GRAD_EN: cfg.grad_en  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KIND:    prdata = APB_DATA_W'(cfg.kind);
      REG_DIR:     prdata = APB_DATA_W'(cfg.backward);
      REG_GRAD_EN: prdata = APB_DATA_W'(cfg.grad_en);
      default:     prdata = '0;
    endcase
  end

endmodule

FILE: src/afbu_datapath.sv
// ----------------------------------------------------------------------------
// afbu_datapath
// Nine-stage activation and gradient pipeline; all stages move together.
// ----------------------------------------------------------------------------
module afbu_datapath
  import afbu_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     in_valid,
  input  logic signed [DATA_W-1:0] x_value,
  input  logic signed [DATA_W-1:0] upstream_grad,
  input  logic signed [DATA_W-1:0] grad_in,
  input  cfg_t                     cfg,
  output logic                     pipe_valid,
  output logic signed [DATA_W-1:0] pipe_result
);

  localparam int STAGES = 9;

  localparam logic [ABS_W-1:0]    MAG_LIMIT = ABS_W'(8) << FRAC_BITS;
  localparam logic [PROD_W:0]     HALF_SIG  = (PROD_W + 1)'(1) << (FRAC_BITS + 3);
  localparam logic [PROD_W:0]     HALF_TANH = (PROD_W + 1)'(1) << (FRAC_BITS + 2);
  localparam logic [ROM_W:0]      RND_Y_TANH = (ROM_W + 1)'(1) << (29 - FRAC_BITS);
  localparam logic [ROM_W:0]      RND_Y_SIG  = (ROM_W + 1)'(1) << (30 - FRAC_BITS);
  localparam logic [LP_W:0]       RND_LP     = (LP_W + 1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [MUL_W-1:0] RND_UP = MUL_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [MUL_W-1:0] RND_DN = RND_UP - MUL_W'(1);
  localparam logic signed [DATA_W+2:0] SAT_MAX = $signed({4'b0000, {(DATA_W-1){1'b1}}});
  localparam logic signed [DATA_W+2:0] SAT_MIN = $signed({4'b1111, {(DATA_W-1){1'b0}}});

  typedef struct packed {
    logic                     is_sig;
    logic                     is_tanh;
    logic                     backward;
    logic                     grad_en;
    logic                     x_pos;
    logic                     x_neg;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] up;
    logic signed [DATA_W-1:0] gi;
  } side_t;

  logic [STAGES:1]           valid_q;
  side_t                     side_q [1:STAGES];
  logic signed [DATA_W-1:0]  fwd_q  [5:STAGES];

  // Stage 0: magnitude, table position.
  side_t                     side_n;
  logic signed [DATA_W:0]    x_ext;
  logic [ABS_W-1:0]          x_abs;
  logic [MAG_W-1:0]          mag;
  logic [POS_W-1:0]          pos;
  logic [POS_W-1:0]          idx_w;
  logic                      full_n;
  logic [SH_W-1:0]           frac_n;
  logic [IDX_W-1:0]          idx_q;
  logic                      full_q;
  logic [SH_W-1:0]           frac_q;

  // Stages 2 to 4: table read, interpolation.
  logic [ROM_W-1:0]          lo_q;
  logic [ROM_W-1:0]          diff_q;
  logic [SH_W-1:0]           frac2_q;
  logic [PROD_W-1:0]         prod_q;
  logic [ROM_W-1:0]          lo3_q;
  logic [PROD_W:0]           interp_sum;
  logic [PROD_W:0]           interp_sh;
  logic [ROM_W-1:0]          th_n;
  logic [ROM_W-1:0]          th_q;

  // Stage 5: output-precision activation.
  logic [ROM_W:0]            s_tanh;
  logic [ROM_W:0]            s_sig;
  logic [ROM_W:0]            s_sig_r;
  logic [LOCAL_W-1:0]        ymag;
  logic signed [DATA_W-1:0]  y_pos;
  logic signed [DATA_W-1:0]  y_n;
  logic signed [DATA_W-1:0]  fwd_n;
  logic signed [DATA_W-1:0]  y_q;

  // Stages 6 to 9: local derivative and gradient product.
  logic [LOCAL_W-1:0]        ya;
  logic [LP_W-1:0]           lp_n;
  logic [LP_W-1:0]           lp_q;
  logic [LP_W:0]             lp_r;
  logic [LOCAL_W-1:0]        rr;
  logic [LOCAL_W-1:0]        local_n;
  logic [LOCAL_W-1:0]        local_q;
  logic signed [MUL_W-1:0]   mul_n;
  logic signed [MUL_W-1:0]   mul_q;
  logic signed [MUL_W-1:0]   mul_bias;
  logic signed [RND_W-1:0]   rnd_n;
  logic signed [RND_W-1:0]   rnd_q;
  logic signed [DATA_W+2:0]  total;
  logic signed [DATA_W-1:0]  grad_res;

  always_comb begin
    side_n.is_sig   = (cfg.kind == KIND_SIGMOID);
    side_n.is_tanh  = (cfg.kind == KIND_TANH);
    side_n.backward = cfg.backward;
    side_n.grad_en  = cfg.grad_en;
    side_n.x_pos    = !x_value[DATA_W-1] && (x_value != '0);
    side_n.x_neg    = x_value[DATA_W-1];
    side_n.x        = x_value;
    side_n.up       = upstream_grad;
    side_n.gi       = grad_in;

    x_ext  = {x_value[DATA_W-1], x_value};
    x_abs  = x_ext[DATA_W] ? ABS_W'($unsigned(-x_ext)) : ABS_W'($unsigned(x_ext));
    mag    = (x_abs > MAG_LIMIT) ? MAG_LIMIT[MAG_W-1:0] : x_abs[MAG_W-1:0];
    pos    = POS_W'(mag) * POS_W'(TABLE_ENTRIES);
    // Sigmoid looks up tanh(x/2), which costs one more fraction bit.
    idx_w  = side_n.is_sig ? (pos >> (FRAC_BITS + 4)) : (pos >> (FRAC_BITS + 3));
    full_n = (idx_w >= POS_W'(TABLE_ENTRIES));
    frac_n = side_n.is_sig ? pos[SH_W-1:0] : {1'b0, pos[SH_W-2:0]};
  end

  always_comb begin
    interp_sum = {1'b0, prod_q} + (side_q[3].is_sig ? HALF_SIG : HALF_TANH);
    interp_sh  = side_q[3].is_sig ? (interp_sum >> (FRAC_BITS + 4))
                                  : (interp_sum >> (FRAC_BITS + 3));
    th_n       = lo3_q + ROM_W'(interp_sh);
  end

  always_comb begin
    s_tanh  = {1'b0, th_q} + RND_Y_TANH;
    s_sig   = side_q[4].x_neg ? ({1'b0, Q30_ONE} - {1'b0, th_q})
                              : ({1'b0, Q30_ONE} + {1'b0, th_q});
    s_sig_r = s_sig + RND_Y_SIG;
    ymag    = side_q[4].is_sig ? LOCAL_W'(s_sig_r >> (31 - FRAC_BITS))
                               : LOCAL_W'(s_tanh >> (30 - FRAC_BITS));
    y_pos   = $signed(DATA_W'(ymag));
    y_n     = (side_q[4].is_tanh && side_q[4].x_neg) ? -y_pos : y_pos;
    if (side_q[4].is_sig || side_q[4].is_tanh) begin
      fwd_n = y_n;
    end else begin
      fwd_n = side_q[4].x_pos ? side_q[4].x : '0;
    end
  end

  always_comb begin
    ya   = y_q[DATA_W-1] ? LOCAL_W'(-y_q) : LOCAL_W'(y_q);
    lp_n = side_q[5].is_sig ? (LP_W'(ya) * LP_W'(ONE_F - ya)) : (LP_W'(ya) * LP_W'(ya));

    lp_r = {1'b0, lp_q} + RND_LP;
    rr   = LOCAL_W'(lp_r >> FRAC_BITS);
    if (side_q[6].is_sig) begin
      local_n = rr;
    end else if (side_q[6].is_tanh) begin
      local_n = ONE_F - rr;
    end else begin
      local_n = side_q[6].x_pos ? ONE_F : '0;
    end

    mul_n    = MUL_W'($signed({1'b0, local_q})) * MUL_W'(side_q[7].up);

    // Half away from zero: negative products take one less before the shift.
    mul_bias = mul_q[MUL_W-1] ? RND_DN : RND_UP;
    rnd_n    = RND_W'((mul_q + mul_bias) >>> FRAC_BITS);

    total    = (DATA_W + 3)'(side_q[STAGES].gi) + (DATA_W + 3)'(rnd_q);
    if (total > SAT_MAX) begin
      grad_res = SAT_MAX[DATA_W-1:0];
    end else if (total < SAT_MIN) begin
      grad_res = SAT_MIN[DATA_W-1:0];
    end else begin
      grad_res = total[DATA_W-1:0];
    end

    if (!side_q[STAGES].backward) begin
      pipe_result = fwd_q[STAGES];
    end else if (!side_q[STAGES].grad_en) begin
      pipe_result = side_q[STAGES].gi;
    end else begin
      pipe_result = grad_res;
    end
  end

  assign pipe_valid = valid_q[STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[STAGES-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_q[1] <= side_n;
      for (int k = 2; k <= STAGES; k++) begin
        side_q[k] <= side_q[k-1];
      end
      idx_q   <= idx_w[IDX_W-1:0];
      full_q  <= full_n;
      frac_q  <= frac_n;
      // Past the last entry tanh is exactly one.
      lo_q    <= full_q ? Q30_ONE : TANH_LO[idx_q];
      diff_q  <= full_q ? '0 : (TANH_HI[idx_q] - TANH_LO[idx_q]);
      frac2_q <= frac_q;
      prod_q  <= PROD_W'(diff_q) * PROD_W'(frac2_q);
      lo3_q   <= lo_q;
      th_q    <= th_n;
      y_q     <= y_n;
      fwd_q[5] <= fwd_n;
      for (int k = 6; k <= STAGES; k++) begin
        fwd_q[k] <= fwd_q[k-1];
      end
      lp_q    <= lp_n;
      local_q <= local_n;
      mul_q   <= mul_n;
      rnd_q   <= rnd_n;
    end
  end

  a_th_bounded: assert property (@(posedge clk) disable iff (rst)
    valid_q[4] |-> th_q <= Q30_ONE)
    else $error("interpolated tanh exceeds one");

  a_local_bounded: assert property (@(posedge clk) disable iff (rst)
    valid_q[7] |-> local_q <= ONE_F)
    else $error("local derivative exceeds one");

  a_sigmoid_range: assert property (@(posedge clk) disable iff (rst)
    valid_q[STAGES] && side_q[STAGES].is_sig && !side_q[STAGES].backward
      |-> !fwd_q[STAGES][DATA_W-1] && (fwd_q[STAGES] <= $signed(DATA_W'(ONE_F))))
    else $error("sigmoid result outside zero to one");

endmodule

FILE: src/activation_forward_backward_unit.sv
// ----------------------------------------------------------------------------
// activation_forward_backward_unit
// Element-wise ReLU, sigmoid or tanh, forward or gradient accumulation.
// ----------------------------------------------------------------------------
// Items pass the nine datapath stages, moving in lock step, then the result
// register. Throughput: one item per cycle while item_stall is low.
// A one-entry skid register behind the result register keeps item_stall a
// registered signal; it rises only while a stalled result has a successor.
// Reset clears the valid bits and sets ReLU, forward, gradients enabled.
// ----------------------------------------------------------------------------
module activation_forward_backward_unit
  import afbu_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic signed [DATA_W-1:0] x_value,
  input  logic signed [DATA_W-1:0] upstream_grad,
  input  logic signed [DATA_W-1:0] grad_in,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic signed [DATA_W-1:0] result_value,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [APB_DATA_W-1:0]    pwdata,
  output logic [APB_DATA_W-1:0]    prdata,
  output logic                     pready
);

  cfg_t                     cfg;
  logic                     adv;
  logic                     pipe_valid;
  logic signed [DATA_W-1:0] pipe_result;
  logic                     skid_valid;
  logic signed [DATA_W-1:0] skid_value;

  afbu_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  afbu_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .in_valid      (item_valid),
    .x_value       (x_value),
    .upstream_grad (upstream_grad),
    .grad_in       (grad_in),
    .cfg           (cfg),
    .pipe_valid    (pipe_valid),
    .pipe_result   (pipe_result)
  );

  // The pipeline holds only while the skid register is occupied.
  assign adv        = !skid_valid;
  assign item_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (!result_stall) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end
    end else if (result_valid && result_stall) begin
      skid_valid <= pipe_valid;
    end else begin
      result_valid <= pipe_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!result_stall) begin
        result_value <= skid_value;
      end
    end else if (result_valid && result_stall) begin
      skid_value <= pipe_result;
    end else begin
      result_value <= pipe_result;
    end
  end

  a_skid_behind_result: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid register occupied without a pending result");

  a_skid_fill_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(result_valid && result_stall && pipe_valid))
    else $error("skid register filled without a stalled result transfer");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall && pipe_valid && !skid_valid |=> skid_valid)
    else $error("finished item lost while the result was stalled");

endmodule

FILE: sim/activation_checker.sv
// ----------------------------------------------------------------------------
// activation_checker
// Predicts and checks every result transfer of the activation unit.
// Tracks register writes on the configuration port, computes the expected
// activation or accumulated gradient for each accepted item transfer and
// compares accepted result transfers in order against those expectations.
// ----------------------------------------------------------------------------
module activation_checker
  import afbu_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  input  logic                     item_stall,
  input  logic signed [DATA_W-1:0] x_value,
  input  logic signed [DATA_W-1:0] upstream_grad,
  input  logic signed [DATA_W-1:0] grad_in,
  input  logic                     result_valid,
  input  logic                     result_stall,
  input  logic signed [DATA_W-1:0] result_value,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic                     pready,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [APB_DATA_W-1:0]    pwdata,
  output int                       outstanding,
  output int                       error_count,
  output int                       checked_count
);

  localparam int     FRAC     = 12;
  localparam int     LUT_SIZE = 256;
  localparam longint UNIT_Q30 = 64'sd1 <<< 30;
  localparam longint ONE_FIX  = 64'sd1 <<< FRAC;

  longint                   tanh_q30 [LUT_SIZE];
  logic [1:0]               cfg_kind;
  logic                     cfg_backward;
  logic                     cfg_grad_en;
  logic signed [DATA_W-1:0] expected_results [$];

  // tanh(8*i/N) in Q30: a truncated Taylor series gives exp(-16/N), which
  // then steps e = exp(-2t) down the table.
  task automatic fill_tanh_table();
    longint unsigned unit;
    longint unsigned step;
    longint unsigned sum;
    longint unsigned term;
    longint unsigned e;
    longint unsigned ratio;
    longint unsigned den;
    unit = 64'd1 << 30;
    step = (64'd1 << 34) / LUT_SIZE;
    sum  = unit;
    term = unit;
    e    = unit;
    for (int k = 1; k <= 14; k++) begin
      term = ((term * step) >> 30) / longint'(k);
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    ratio = sum;
    for (int i = 0; i < LUT_SIZE; i++) begin
      den         = unit + e;
      tanh_q30[i] = longint'((((unit - e) << 30) + den / 2) / den);
      e           = (e * ratio + (unit >> 1)) >> 30;
    end
  endtask

  initial fill_tanh_table();

  function automatic longint round_away(longint v, int sh);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
    return (v < 0) ? -mag : mag;
  endfunction

  // tanh of mag / 2^(FRAC+extra) in Q30, interpolated between table points.
  function automatic longint tanh_interp(longint mag, int extra);
    int     sh;
    longint pos;
    longint idx;
    longint frac;
    longint lo;
    longint hi;
    sh   = FRAC + 3 + extra;
    pos  = mag * LUT_SIZE;
    idx  = pos >>> sh;
    frac = pos & ((64'sd1 <<< sh) - 1);
    if (idx >= LUT_SIZE) begin
      return UNIT_Q30;
    end
    lo = tanh_q30[idx];
    hi = (idx + 1 < LUT_SIZE) ? tanh_q30[idx + 1] : UNIT_Q30;
    return lo + round_away((hi - lo) * frac, sh);
  endfunction

  function automatic longint clamped_mag(longint x);
    longint m;
    m = (x < 0) ? -x : x;
    return (m > (64'sd8 <<< FRAC)) ? (64'sd8 <<< FRAC) : m;
  endfunction

  function automatic longint tanh_fix(longint x);
    longint y;
    y = round_away(tanh_interp(clamped_mag(x), 0), 30 - FRAC);
    return (x < 0) ? -y : y;
  endfunction

  function automatic longint sigmoid_fix(longint x);
    longint th;
    th = tanh_interp(clamped_mag(x), 1);
    return round_away((x < 0) ? UNIT_Q30 - th : UNIT_Q30 + th, 31 - FRAC);
  endfunction

  function automatic logic signed [DATA_W-1:0] predict_element(
    logic signed [DATA_W-1:0] x, logic signed [DATA_W-1:0] up,
    logic signed [DATA_W-1:0] gi);
    longint xv;
    longint res;
    longint y;
    longint deriv;
    xv = x;
    if (!cfg_backward) begin
      case (cfg_kind)
        KIND_SIGMOID: res = sigmoid_fix(xv);
        KIND_TANH:    res = tanh_fix(xv);
        default:      res = (xv > 0) ? xv : 0;
      endcase
    end else if (!cfg_grad_en) begin
      res = gi;
    end else begin
      case (cfg_kind)
        KIND_SIGMOID: begin
          y     = sigmoid_fix(xv);
          deriv = round_away(y * (ONE_FIX - y), FRAC);
        end
        KIND_TANH: begin
          y     = tanh_fix(xv);
          deriv = ONE_FIX - round_away(y * y, FRAC);
        end
        default: deriv = (xv > 0) ? ONE_FIX : 0;
      endcase
      res = longint'(gi) + round_away(deriv * longint'(up), FRAC);
    end
    if (res > 32767) begin
      res = 32767;
    end else if (res < -32768) begin
      res = -32768;
    end
    return res[DATA_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic signed [DATA_W-1:0] want;
    int                       bad;
    int                       seen;
    bad  = 0;
    seen = 0;
    if (rst) begin
      cfg_kind     = KIND_RELU;
      cfg_backward = 1'b0;
      cfg_grad_en  = 1'b1;
      expected_results.delete();
      outstanding   <= 0;
      error_count   <= 0;
      checked_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_KIND:    cfg_kind     = pwdata[1:0];
          REG_DIR:     cfg_backward = pwdata[0];
          REG_GRAD_EN: cfg_grad_en  = pwdata[0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall) begin
        expected_results.push_back(predict_element(x_value, upstream_grad, grad_in));
      end
      if (result_valid && !result_stall) begin
        seen = 1;
        if (expected_results.size() == 0) begin
          $error("result_value: expected no transfer, actual %0d", result_value);
          bad++;
        end else begin
          want = expected_results.pop_front();
          if (result_value !== want) begin
            $error("result_value: expected %0d, actual %0d", want, result_value);
            bad++;
          end
        end
      end
      outstanding   <= expected_results.size();
      error_count   <= error_count + bad;
      checked_count <= checked_count + seen;
    end
  end

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the activation forward/backward unit.
// Drives element transfers under every activation kind, direction and
// gradient setting, with random idling on both channels and one long
// receiver hold-off; the checker beside the block does the comparison.
// ----------------------------------------------------------------------------
module testbench;
  import afbu_pkg::*;

  localparam int                   RANDOM_ITEMS  = 1100;
  localparam int                   SETTLE_CYCLES = 12;
  localparam int                   IDLE_LIMIT    = 4000;
  localparam int                   HOLD_CYCLES   = 250;
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED  = 2'd3;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     item_valid;
  logic                     item_stall;
  logic signed [DATA_W-1:0] x_value;
  logic signed [DATA_W-1:0] upstream_grad;
  logic signed [DATA_W-1:0] grad_in;
  logic                     result_valid;
  logic                     result_stall;
  logic signed [DATA_W-1:0] result_value;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [ADDR_W-1:0]        paddr;
  logic [APB_DATA_W-1:0]    pwdata;
  logic [APB_DATA_W-1:0]    prdata;
  logic                     pready;

  int outstanding;
  int error_count;
  int checked_count;

  int elements_sent;
  int settings_used;
  int no_gap_left;
  bit steady;
  int hold_requests;

  activation_forward_backward_unit DUT (.*);
  activation_checker checker_inst (.*);

  always #5 clk = ~clk;

  // Receiver: calm stretches, short stalls, the odd long one, and a long
  // hold-off whenever the stimulus asks for one.
  initial begin
    int hold_left;
    int phase_left;
    int served;
    int pick;
    bit calm;
    hold_left  = 0;
    phase_left = 0;
    served     = 0;
    calm       = 1'b1;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else if (served != hold_requests) begin
        served++;
        hold_left = HOLD_CYCLES - 1;
        result_stall <= 1'b1;
      end else begin
        if (phase_left == 0) begin
          calm       = ($urandom_range(0, 3) == 0);
          phase_left = $urandom_range(20, 200);
        end
        phase_left--;
        pick = $urandom_range(0, 99);
        if (calm || pick >= 30) begin
          result_stall <= 1'b0;
        end else if (pick < 3) begin
          hold_left = $urandom_range(20, 80);
          result_stall <= 1'b1;
        end else begin
          hold_left = $urandom_range(0, 3);
          result_stall <= 1'b1;
        end
      end
    end
  end

  // Watchdog: ends the run once nothing has been transferred for too long.
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
          (psel && penable && pwrite)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int pick_gap();
    int pick;
    if (no_gap_left > 0 || steady) begin
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      return 0;
    end else if (pick < 85) begin
      return $urandom_range(1, 3);
    end else if (pick < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Only the low field bits of the returned value are driven.
  function automatic int pick_value();
    int v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 6))
          0:       v = -32768;
          1:       v = 32767;
          2:       v = 0;
          3:       v = 1;
          4:       v = -1;
          5:       v = 4096;
          default: v = -4096;
        endcase
      end
      1, 2, 3: v = $urandom;
      default: v = $urandom_range(0, 24576) - 12288;
    endcase
    return v;
  endfunction

  task automatic send_element(input int x, input int up, input int gi);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid    <= 1'b1;
    x_value       <= x[DATA_W-1:0];
    upstream_grad <= up[DATA_W-1:0];
    grad_in       <= gi[DATA_W-1:0];
    @(posedge clk);
    while (item_stall) @(posedge clk);
    elements_sent++;
    if (no_gap_left > 0) begin
      no_gap_left--;
    end
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                           input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Registers change only once the pipeline has drained.
  task automatic apply_setting(input logic [1:0] kind, input logic backward,
                               input logic grad_en);
    logic [APB_DATA_W-1:0] junk;
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    junk = $urandom;
    write_reg(REG_KIND, {junk[APB_DATA_W-1:2], kind});
    write_reg(REG_DIR, {junk[APB_DATA_W-1:1], backward});
    write_reg(REG_GRAD_EN, {~junk[APB_DATA_W-1:1], grad_en});
    settings_used++;
  endtask

  initial begin
    logic [1:0] kind;
    logic       backward;
    logic       grad_en;
    int         phase;
    int         count;
    int         random_sent;
    bit         squeezed;
    rst           <= 1'b1;
    item_valid    <= 1'b0;
    x_value       <= '0;
    upstream_grad <= '0;
    grad_in       <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    elements_sent = 0;
    settings_used = 0;
    no_gap_left   = 0;
    steady        = 1'b0;
    hold_requests <= 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes under each kind and direction, saturation
    // of the accumulated gradient, the unused kind code and disabled
    // gradients. The forward pass must ignore the gradient enable.
    apply_setting(KIND_RELU, 1'b0, 1'b1);
    send_element(-32768, 32767, -32768);
    send_element(32767, -32768, 32767);
    send_element(0, -1, -1);
    apply_setting(KIND_SIGMOID, 1'b0, 1'b0);
    send_element(-32768, 0, 0);
    send_element(32767, 0, 0);
    send_element(0, 0, 0);
    send_element(1, 0, 0);
    apply_setting(KIND_TANH, 1'b0, 1'b1);
    send_element(-32768, 0, 0);
    send_element(32767, 0, 0);
    send_element(-1, 0, 0);
    send_element(4096, 0, 0);
    apply_setting(2'(KIND_TANH | KIND_SIGMOID), 1'b0, 1'b1);
    write_reg(REG_UNMAPPED, $urandom);
    send_element(-5, 0, 0);
    send_element(5, 0, 0);
    apply_setting(KIND_RELU, 1'b1, 1'b1);
    send_element(32767, 32767, 32767);
    send_element(1, -32768, -32768);
    send_element(0, 32767, 5);
    apply_setting(KIND_SIGMOID, 1'b1, 1'b1);
    send_element(0, 32767, 0);
    send_element(-32768, -32768, 32767);
    apply_setting(KIND_TANH, 1'b1, 1'b1);
    send_element(0, -32768, -32768);
    send_element(32767, 1000, 0);
    apply_setting(2'(KIND_TANH | KIND_SIGMOID), 1'b1, 1'b1);
    send_element(100, -4096, 7);
    apply_setting(KIND_TANH, 1'b1, 1'b0);
    send_element(1234, 32767, -32768);
    send_element(0, -1, 32767);

    // Random phases: the first sixteen walk every combination of settings.
    random_sent = 0;
    squeezed    = 1'b0;
    phase       = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (phase < 16) begin
        kind     = phase[1:0];
        backward = phase[2];
        grad_en  = !phase[3];
      end else begin
        kind     = 2'($urandom_range(0, 3));
        backward = $urandom_range(0, 3) != 0;
        grad_en  = $urandom_range(0, 4) != 0;
      end
      apply_setting(kind, backward, grad_en);
      steady = ($urandom_range(0, 3) == 0);
      count  = $urandom_range(40, 100);
      for (int j = 0; j < count && random_sent < RANDOM_ITEMS; j++) begin
        // Hold the receiver off while items keep coming, to fill the block.
        if (!squeezed && random_sent >= RANDOM_ITEMS / 2) begin
          squeezed = 1'b1;
          no_gap_left = 60;
          hold_requests <= hold_requests + 1;
        end
        send_element(pick_value(), pick_value(), pick_value());
        random_sent++;
      end
      phase++;
    end

    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Run covered %0d element transfers across %0d register settings,",
             elements_sent, settings_used);
    $display("with %0d result transfers compared against the prediction.",
             checked_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/afbu_pkg.sv
src/afbu_regs.sv
src/afbu_datapath.sv
src/activation_forward_backward_unit.sv
sim/activation_checker.sv
sim/testbench.sv
